>>> src/triangle_barycentric_coords_unit_assert.svh
// assertion macros used by the checker file
`ifndef TRIANGLE_BARYCENTRIC_COORDS_UNIT_ASSERT_SVH
`define TRIANGLE_BARYCENTRIC_COORDS_UNIT_ASSERT_SVH
// implication checked on every rising clock edge, reset masks it
`define TBC_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("check failed");
// next-cycle implication
`define TBC_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("check failed");
`endif

>>> src/tbc_pkg.sv
// shared widths, constants and types of the barycentric unit
package tbc_pkg;
  localparam int OUT_BITS = 32;
  localparam logic signed [OUT_BITS-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [OUT_BITS-1:0] SAT_MIN = 32'sh8000_0000;
  localparam logic signed [OUT_BITS-1:0] ONE_Q16 = 32'sh0001_0000;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] u;
    logic signed [OUT_BITS-1:0] v;
    logic signed [OUT_BITS-1:0] w;
    logic                       degen;
  } tbc_res_t;
endpackage

>>> src/tbc_div.sv
// pipelined restoring divider: one quotient bit per stage, sign-magnitude
module tbc_div import tbc_pkg::*; #(
  parameter int NW = 64,
  parameter int DW = 64
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [NW-1:0]        num,
  input  logic [DW-1:0]        den,
  input  logic                 neg_in,
  output logic [NW-1:0]        quo,
  output logic                 neg_out
);
  // stage arrays of the pipeline
  logic [NW-1:0] q_r   [0:NW];
  logic [NW-1:0] n_r   [0:NW];
  logic [DW:0]   rem_r [0:NW];
  logic [DW-1:0] d_r   [0:NW];
  logic          s_r   [0:NW];

  always_comb begin
    q_r[0]   = '0;
    n_r[0]   = num;
    rem_r[0] = '0;
    d_r[0]   = den;
    s_r[0]   = neg_in;
  end

  genvar i;
  generate
    for (i = 0; i < NW; i++) begin : g_st
      logic [DW:0] sh;
      logic [DW+1:0] diff;
      assign sh   = {rem_r[i][DW-1:0], n_r[i][NW-1]};
      assign diff = {1'b0, sh} - {2'b00, d_r[i]};
      always_ff @(posedge clk) begin
        if (en) begin
          n_r[i+1]   <= {n_r[i][NW-2:0], 1'b0};
          d_r[i+1]   <= d_r[i];
          s_r[i+1]   <= s_r[i];
          if (!diff[DW+1]) begin
            rem_r[i+1] <= diff[DW:0];
            q_r[i+1]   <= {q_r[i][NW-2:0], 1'b1};
          end else begin
            rem_r[i+1] <= sh;
            q_r[i+1]   <= {q_r[i][NW-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  assign quo     = q_r[NW];
  assign neg_out = s_r[NW];
endmodule

>>> src/tbc_front.sv
// edge vectors, dot products and determinants over registered stages
module tbc_front import tbc_pkg::*; #(
  parameter int CB = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [CB-1:0]   a_x, a_y, a_z, b_x, b_y, b_z,
  input  logic signed [CB-1:0]   c_x, c_y, c_z, p_x, p_y, p_z,
  output logic signed [4*CB+7:0] det,
  output logic signed [4*CB+7:0] du,
  output logic signed [4*CB+7:0] dv
);
  localparam int EW = CB + 1;
  localparam int PW = 2 * EW;
  localparam int DTW = PW + 2;
  localparam int XW = 4 * CB + 8;

  logic signed [EW-1:0] e0_r [0:2], e1_r [0:2], e2_r [0:2];
  logic signed [PW-1:0] p00_r [0:2], p01_r [0:2], p11_r [0:2], p20_r [0:2], p21_r [0:2];
  logic signed [DTW-1:0] d00_r, d01_r, d11_r, d20_r, d21_r;
  logic signed [XW-1:0] m0_r, m1_r, m2_r, m3_r, m4_r, m5_r;
  logic signed [XW-1:0] det_r, du_r, dv_r;

  always_ff @(posedge clk) begin
    if (en) begin
      e0_r[0] <= EW'(b_x) - EW'(a_x);
      e0_r[1] <= EW'(b_y) - EW'(a_y);
      e0_r[2] <= EW'(b_z) - EW'(a_z);
      e1_r[0] <= EW'(c_x) - EW'(a_x);
      e1_r[1] <= EW'(c_y) - EW'(a_y);
      e1_r[2] <= EW'(c_z) - EW'(a_z);
      e2_r[0] <= EW'(p_x) - EW'(a_x);
      e2_r[1] <= EW'(p_y) - EW'(a_y);
      e2_r[2] <= EW'(p_z) - EW'(a_z);
      for (int k = 0; k < 3; k++) begin
        p00_r[k] <= PW'(e0_r[k]) * PW'(e0_r[k]);
        p01_r[k] <= PW'(e0_r[k]) * PW'(e1_r[k]);
        p11_r[k] <= PW'(e1_r[k]) * PW'(e1_r[k]);
        p20_r[k] <= PW'(e2_r[k]) * PW'(e0_r[k]);
        p21_r[k] <= PW'(e2_r[k]) * PW'(e1_r[k]);
      end
      d00_r <= DTW'(p00_r[0]) + DTW'(p00_r[1]) + DTW'(p00_r[2]);
      d01_r <= DTW'(p01_r[0]) + DTW'(p01_r[1]) + DTW'(p01_r[2]);
      d11_r <= DTW'(p11_r[0]) + DTW'(p11_r[1]) + DTW'(p11_r[2]);
      d20_r <= DTW'(p20_r[0]) + DTW'(p20_r[1]) + DTW'(p20_r[2]);
      d21_r <= DTW'(p21_r[0]) + DTW'(p21_r[1]) + DTW'(p21_r[2]);
      m0_r <= XW'(d00_r) * XW'(d11_r);
      m1_r <= XW'(d01_r) * XW'(d01_r);
      m2_r <= XW'(d20_r) * XW'(d11_r);
      m3_r <= XW'(d01_r) * XW'(d21_r);
      m4_r <= XW'(d00_r) * XW'(d21_r);
      m5_r <= XW'(d20_r) * XW'(d01_r);
      det_r <= m0_r - m1_r;
      du_r  <= m2_r - m3_r;
      dv_r  <= m4_r - m5_r;
    end
  end

  assign det = det_r;
  assign du  = du_r;
  assign dv  = dv_r;
endmodule

>>> src/triangle_barycentric_coords_unit.sv
// top level: barycentric weights of a point against a triangle
// usage:
//   in_tdata carries twelve signed coordinates (a, b, c vertices, then p),
//   each COORD_BITS wide, a_x in the lowest bits. one request per clock unless stalled.
//   out_tdata carries weight_u, weight_v, weight_w (signed Q16.16), out_tuser
//   carries degenerate (zero determinant, weights forced to zero).
// pipeline: 5 front stages, 4*COORD_BITS+24 divider stages, then the output
//   register, which takes w and the saturation from the last divider stage.
//   throughput is one request per clock while the output is not stalled, set
//   by the fully pipelined divider (one quotient bit per stage).
// stall: the whole pipeline freezes while the output register holds a
//   request that is not taken; in_tready is high whenever the output is
//   empty or being taken, so nothing is lost or repeated.
// reset: all valid bits clear; data registers are not reset.
// area grows with COORD_BITS because the divider length follows the
//   determinant width.
module triangle_barycentric_coords_unit import tbc_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // a_x a_y a_z b_x b_y b_z c_x c_y c_z p_x p_y p_z, zero-padded to bytes
  input  logic [((12*COORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // weight_u weight_v weight_w
  output logic [3*OUT_BITS-1:0]     out_tdata,
  // degenerate
  output logic                      out_tuser
);
  localparam int CB = COORD_BITS;
  localparam int XW = 4 * CB + 8;
  localparam int NW = XW + 16;
  localparam int FL = 5;
  localparam int DL = NW;
  localparam int TL = FL + DL + 1;

  logic en;
  logic out_v_r;
  tbc_res_t out_r;
  logic [TL-1:0] vld_r;

  assign en = !out_v_r || out_tready;
  assign in_tready = en;

  logic signed [CB-1:0] crd [0:11];
  genvar g;
  generate
    for (g = 0; g < 12; g++) begin : g_crd
      assign crd[g] = in_tdata[g*CB +: CB];
    end
  endgenerate

  logic signed [XW-1:0] det, du, dv;
  tbc_front #(.CB(CB)) u_front (
    .clk(clk), .en(en),
    .a_x(crd[0]), .a_y(crd[1]), .a_z(crd[2]),
    .b_x(crd[3]), .b_y(crd[4]), .b_z(crd[5]),
    .c_x(crd[6]), .c_y(crd[7]), .c_z(crd[8]),
    .p_x(crd[9]), .p_y(crd[10]), .p_z(crd[11]),
    .det(det), .du(du), .dv(dv)
  );

  // magnitudes for the dividers
  logic [NW-1:0] nu_mag, nv_mag;
  logic [XW-1:0] d_mag;
  logic signed [NW-1:0] nu_s, nv_s;
  assign nu_s   = {du, 16'h0000};
  assign nv_s   = {dv, 16'h0000};
  assign nu_mag = nu_s[NW-1] ? NW'(-nu_s) : NW'(nu_s);
  assign nv_mag = nv_s[NW-1] ? NW'(-nv_s) : NW'(nv_s);
  assign d_mag  = det[XW-1] ? XW'(-det) : XW'(det);

  logic [NW-1:0] qu, qv;
  logic nu_o, nv_o;
  tbc_div #(.NW(NW), .DW(XW)) u_div_u (
    .clk(clk), .en(en), .num(nu_mag), .den(d_mag),
    .neg_in(nu_s[NW-1] ^ det[XW-1]), .quo(qu), .neg_out(nu_o)
  );
  tbc_div #(.NW(NW), .DW(XW)) u_div_v (
    .clk(clk), .en(en), .num(nv_mag), .den(d_mag),
    .neg_in(nv_s[NW-1] ^ det[XW-1]), .quo(qv), .neg_out(nv_o)
  );

  // degenerate flag delayed alongside the divider
  logic dg_r [0:DL-1];
  always_ff @(posedge clk) begin
    if (en) begin
      dg_r[0] <= (det == '0);
      for (int k = 1; k < DL; k++) dg_r[k] <= dg_r[k-1];
    end
  end

  function automatic logic signed [OUT_BITS-1:0] sat_q(input logic [NW-1:0] q,
                                                       input logic neg);
    logic big;
    big = (q[NW-1:OUT_BITS] != '0);
    if (!neg) sat_q = (big || q[OUT_BITS-1]) ? SAT_MAX : q[OUT_BITS-1:0];
    else if (big || q[OUT_BITS-1:0] > 32'h8000_0000) sat_q = SAT_MIN;
    else sat_q = -q[OUT_BITS-1:0];
  endfunction

  logic signed [OUT_BITS-1:0] us, vs;
  logic signed [OUT_BITS+1:0] ws;
  tbc_res_t res_nxt;
  always_comb begin
    us = sat_q(qu, nu_o);
    vs = sat_q(qv, nv_o);
    ws = (OUT_BITS+2)'(ONE_Q16) - (OUT_BITS+2)'(us) - (OUT_BITS+2)'(vs);
    res_nxt.degen = dg_r[DL-1];
    res_nxt.u = res_nxt.degen ? '0 : us;
    res_nxt.v = res_nxt.degen ? '0 : vs;
    if (res_nxt.degen) res_nxt.w = '0;
    else if (ws > (OUT_BITS+2)'(SAT_MAX)) res_nxt.w = SAT_MAX;
    else if (ws < (OUT_BITS+2)'(SAT_MIN)) res_nxt.w = SAT_MIN;
    else res_nxt.w = ws[OUT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      vld_r   <= {vld_r[TL-2:0], in_tvalid};
      out_v_r <= vld_r[TL-2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= res_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_r.w, out_r.v, out_r.u};
  assign out_tuser  = out_r.degen;
endmodule

>>> src/tbc_checker.sv
// port-level checker for the barycentric unit and its bind
`include "triangle_barycentric_coords_unit_assert.svh"
module tbc_checker import tbc_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [3*OUT_BITS-1:0] out_tdata,
  input logic                  out_tuser
);
  `TBC_ASSERT_IMPL(a_degen_zero, clk, rst_n, out_tvalid && out_tuser, out_tdata == '0)
  `TBC_ASSERT_IMPL(a_ready_free, clk, rst_n, !out_tvalid || out_tready, in_tready)
  `TBC_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule

bind triangle_barycentric_coords_unit tbc_checker u_tbc_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata), .out_tuser(out_tuser)
);

>>> test/triangle_barycentric_coords_unit_tb.sv
// testbench for the barycentric weight unit: directed table plus random triangles
`timescale 1ns / 1ps

module triangle_barycentric_coords_unit_tb;
  import tbc_pkg::*;

  localparam int COORD_BITS = 16;
  localparam int DATA_BITS  = 12 * COORD_BITS;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 4 * COORD_BITS + 60;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    logic [DATA_BITS-1:0] data;
    bit                   typed;
    tbc_res_t             res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DATA_BITS-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [3*OUT_BITS-1:0] out_tdata;
  logic out_tuser;

  tbc_res_t weights_due[$];
  row_t     table_rows[$];
  bit       in_fire = 1'b0, out_fire = 1'b0;
  bit       cur_typed = 1'b0;
  tbc_res_t cur_res;
  bit       idle_on = 1'b1;
  bit       long_hold = 1'b0;
  int       stall_left = 0;
  int       errors = 0;

  triangle_barycentric_coords_unit #(.COORD_BITS(COORD_BITS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  function automatic wide_t clamp_q16(input wide_t x);
    if (x > wide_t'(SAT_MAX)) return wide_t'(SAT_MAX);
    if (x < wide_t'(SAT_MIN)) return wide_t'(SAT_MIN);
    return x;
  endfunction

  // exact cramer's rule, quotient truncated toward zero then clamped
  function automatic tbc_res_t barycentric_weights(input logic [DATA_BITS-1:0] d);
    coord_t crd[12];
    wide_t e0[3], e1[3], e2[3];
    wide_t d00, d01, d11, d20, d21, det, du, dv, u, v, w;
    tbc_res_t r;
    for (int k = 0; k < 12; k++) crd[k] = d[COORD_BITS*k +: COORD_BITS];
    for (int k = 0; k < 3; k++) begin
      e0[k] = wide_t'(crd[3+k]) - wide_t'(crd[k]);
      e1[k] = wide_t'(crd[6+k]) - wide_t'(crd[k]);
      e2[k] = wide_t'(crd[9+k]) - wide_t'(crd[k]);
    end
    d00 = e0[0]*e0[0] + e0[1]*e0[1] + e0[2]*e0[2];
    d01 = e0[0]*e1[0] + e0[1]*e1[1] + e0[2]*e1[2];
    d11 = e1[0]*e1[0] + e1[1]*e1[1] + e1[2]*e1[2];
    d20 = e2[0]*e0[0] + e2[1]*e0[1] + e2[2]*e0[2];
    d21 = e2[0]*e1[0] + e2[1]*e1[1] + e2[2]*e1[2];
    det = d00*d11 - d01*d01;
    if (det == 0) begin
      r.u = '0; r.v = '0; r.w = '0; r.degen = 1'b1;
      return r;
    end
    du = d20*d11 - d01*d21;
    dv = d00*d21 - d20*d01;
    u = clamp_q16((du * 65536) / det);
    v = clamp_q16((dv * 65536) / det);
    w = clamp_q16(65536 - u - v);
    r.u = u[31:0]; r.v = v[31:0]; r.w = w[31:0]; r.degen = 1'b0;
    return r;
  endfunction

  function automatic logic [DATA_BITS-1:0] pack_coords(input int c[12]);
    logic [DATA_BITS-1:0] d;
    for (int k = 0; k < 12; k++) d[COORD_BITS*k +: COORD_BITS] = c[k][COORD_BITS-1:0];
    return d;
  endfunction

  function automatic tbc_res_t weights(input int u, input int v, input int w, input bit dg);
    tbc_res_t r;
    r.u = u; r.v = v; r.w = w; r.degen = dg;
    return r;
  endfunction

  task automatic add_row(input int c[12], input bit typed, input tbc_res_t res);
    row_t r;
    r.data = pack_coords(c); r.typed = typed; r.res = res;
    table_rows.push_back(r);
  endtask

  // request accept, prediction and result check all on the rising edge
  always @(posedge clk) begin
    tbc_res_t got, want;
    in_fire  <= in_tvalid && in_tready;
    out_fire <= out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready)
      weights_due.push_back(cur_typed ? cur_res : barycentric_weights(in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      got.u = out_tdata[0 +: OUT_BITS];
      got.v = out_tdata[OUT_BITS +: OUT_BITS];
      got.w = out_tdata[2*OUT_BITS +: OUT_BITS];
      got.degen = out_tuser;
      if (weights_due.size() == 0) begin
        $display("%0t: result with nothing pending: u=%0d v=%0d w=%0d degen=%0b",
                 $time, got.u, got.v, got.w, got.degen);
        errors++;
      end else begin
        want = weights_due.pop_front();
        if (got.u !== want.u) begin
          $display("%0t: weight_u expected %0d actual %0d", $time, want.u, got.u); errors++;
        end
        if (got.v !== want.v) begin
          $display("%0t: weight_v expected %0d actual %0d", $time, want.v, got.v); errors++;
        end
        if (got.w !== want.w) begin
          $display("%0t: weight_w expected %0d actual %0d", $time, want.w, got.w); errors++;
        end
        if (got.degen !== want.degen) begin
          $display("%0t: degenerate expected %0b actual %0b", $time, want.degen, got.degen);
          errors++;
        end
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    int s;
    s = stall_left;
    if (out_fire) s = idle_on ? $urandom_range(0, 19) : 0;
    if (long_hold) begin
      s = HOLD_CYCLES;
      long_hold = 1'b0;
    end
    if (!rst_n) out_tready <= 1'b0;
    else if (s > 0) begin
      out_tready <= 1'b0;
      s--;
    end else out_tready <= 1'b1;
    stall_left = s;
  end

  task automatic send_request(input logic [DATA_BITS-1:0] d, input bit typed, input tbc_res_t res);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    cur_typed = typed;
    cur_res   = res;
    do @(negedge clk); while (!in_fire);
  endtask

  function automatic logic [DATA_BITS-1:0] random_triangle();
    int c[12];
    int sel, lim;
    sel = $urandom_range(0, 9);
    for (int k = 0; k < 12; k++) c[k] = $urandom_range(0, 65535) - 32768;
    if (sel >= 6 && sel <= 7) begin
      lim = $urandom_range(1, 2048);
      for (int k = 0; k < 12; k++) c[k] = $urandom_range(0, 2 * lim) - lim;
    end else if (sel == 8) begin
      // third vertex takes each coordinate from a or b; coincident when all come from one
      for (int k = 0; k < 3; k++)
        c[6+k] = ($urandom_range(0, 1) != 0) ? c[k] : c[3+k];
    end else if (sel == 9) begin
      // tiny triangle, far point: quotients run into the clamp
      for (int k = 0; k < 3; k++) begin
        c[3+k] = c[k] + $urandom_range(0, 4) - 2;
        c[6+k] = c[k] + $urandom_range(0, 4) - 2;
        if (c[3+k] > 32767 || c[3+k] < -32768) c[3+k] = c[k];
        if (c[6+k] > 32767 || c[6+k] < -32768) c[6+k] = c[k];
      end
    end
    return pack_coords(c);
  endfunction

  initial begin
    tbc_res_t none;
    none = weights(0, 0, 0, 0);
    add_row('{0,0,0, 0,0,0, 0,0,0, 0,0,0}, 1, weights(0, 0, 0, 1));
    add_row('{0,0,0, 256,0,0, 0,256,0, 0,0,0}, 1, weights(0, 0, 65536, 0));
    add_row('{0,0,0, 256,0,0, 0,256,0, 256,0,0}, 1, weights(65536, 0, 0, 0));
    add_row('{0,0,0, 256,0,0, 0,256,0, 0,256,0}, 1, weights(0, 65536, 0, 0));
    add_row('{0,0,0, 256,0,0, 0,256,0, 128,128,0}, 1, weights(32768, 32768, 0, 0));
    add_row('{0,0,0, 256,0,0, 0,256,0, 0,0,256}, 1, weights(0, 0, 65536, 0));
    add_row('{0,0,0, 256,0,0, 256,0,0, 5,7,9}, 1, weights(0, 0, 0, 1));
    add_row('{32767,32767,32767, 32767,32767,32767, 32767,32767,32767,
              32767,32767,32767}, 1, weights(0, 0, 0, 1));
    add_row('{-32768,-32768,-32768, -32768,-32768,-32768, -32768,-32768,-32768,
              -32768,-32768,-32768}, 1, weights(0, 0, 0, 1));
    add_row('{-32768,-32768,-32768, 32767,32767,32767, 32767,-32768,0, 0,0,0}, 0, none);
    add_row('{32767,32767,32767, -32768,-32768,-32768, -32768,32767,0,
              -32768,32767,-32768}, 0, none);
    add_row('{0,0,0, 1,0,0, 0,1,0, 32767,32767,32767}, 0, none);
    add_row('{0,0,0, 1,0,0, 0,1,0, -32768,-32768,-32768}, 0, none);
    add_row('{0,0,0, 1,0,0, 0,1,0, 32767,-32768,0}, 0, none);
    add_row('{-100,50,3, 400,-20,7, 30,900,-11, 12,13,14}, 0, none);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (table_rows[i]) send_request(table_rows[i].data, table_rows[i].typed, table_rows[i].res);

    for (int n = 0; n < 1100; n++) begin
      if (n % 100 == 0) idle_on = ($urandom_range(0, 2) != 0);
      if (n == 300) long_hold = 1'b1;
      if (n == 600) begin
        in_tvalid <= 1'b0;
        while (weights_due.size() != 0) @(negedge clk);
      end
      send_request(random_triangle(), 0, none);
    end
    in_tvalid <= 1'b0;
    cur_typed = 1'b0;
    while (weights_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
